/* hw/rtl/rcpa_pkg.sv */
// ----------------------------------------------------------------------------
// rcpa_pkg
// Shared widths, defaults and codes for the refcounted page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpa_pkg;

    // Fixed field widths of the channels
    localparam int PAGE_W     = 14;
    localparam int ACTION_W   = 3;
    localparam int STATUS_W   = 2;
    localparam int REF_OUT_W  = 8;
    localparam int FREE_OUT_W = 15;

    // Default sizing
    localparam int NUM_PAGES_DEF = 16384;
    localparam int REF_WIDTH_DEF = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 3'd0,
        ACT_FREE  = 3'd1,
        ACT_SEED  = 3'd2,
        ACT_INC   = 3'd3,
        ACT_DEC   = 3'd4,
        ACT_QUERY = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_BAD   = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

endpackage

`default_nettype wire

/* hw/rtl/rcpa_ram.sv */
// ----------------------------------------------------------------------------
// rcpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rcpa_clear.sv */
// ----------------------------------------------------------------------------
// rcpa_clear
// Post-reset sweep that zeroes the reference count memory, one entry a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpa_clear
    import rcpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    output logic                              clr_busy,
    output logic [$clog2(NUM_PAGES)-1:0]      clr_addr
);

    localparam int AW = $clog2(NUM_PAGES);

    logic          busy_reg, busy_next;
    logic [AW-1:0] addr_reg, addr_next;

    always_comb begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        if (busy_reg) begin
            addr_next = addr_reg + AW'(1);
            if (addr_reg == AW'(NUM_PAGES - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    assign clr_busy = busy_reg;
    assign clr_addr = addr_reg;

endmodule

`default_nettype wire

/* hw/rtl/rcpa_core.sv */
// ----------------------------------------------------------------------------
// rcpa_core
// Sequencer: reads count and stack memories on accept, updates and writes
// back in S_EXEC once the result register can take the result, keeps the stack pointer and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpa_core
    import rcpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int REF_WIDTH = REF_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration
    input  wire logic                             cfg_wr_en,
    input  wire logic [PAGE_W-1:0]                cfg_wr_data,
    // input channel
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [ACTION_W-1:0]              s_action,
    input  wire logic [PAGE_W-1:0]                s_page,
    // result channel
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [STATUS_W-1:0]                   m_status,
    output logic [PAGE_W-1:0]                     m_page_out,
    output logic [REF_OUT_W-1:0]                  m_ref_count,
    output logic [FREE_OUT_W-1:0]                 m_free_pages,
    // clearing sweep
    input  wire logic                             clr_busy,
    input  wire logic [$clog2(NUM_PAGES)-1:0]     clr_addr,
    // count memory
    output logic                                  ref_rd_en,
    output logic [$clog2(NUM_PAGES)-1:0]          ref_rd_addr,
    input  wire logic [REF_WIDTH-1:0]             ref_rd_data,
    output logic                                  ref_wr_en,
    output logic [$clog2(NUM_PAGES)-1:0]          ref_wr_addr,
    output logic [REF_WIDTH-1:0]                  ref_wr_data,
    // free stack memory
    output logic                                  stk_rd_en,
    output logic [$clog2(NUM_PAGES)-1:0]          stk_rd_addr,
    input  wire logic [PAGE_W-1:0]                stk_rd_data,
    output logic                                  stk_wr_en,
    output logic [$clog2(NUM_PAGES)-1:0]          stk_wr_addr,
    output logic [PAGE_W-1:0]                     stk_wr_data
);

    localparam int AW = $clog2(NUM_PAGES);
    localparam int CW = $clog2(NUM_PAGES + 1);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t                state_reg, state_next;
    logic [ACTION_W-1:0]   act_reg, act_next;
    logic [PAGE_W-1:0]     page_reg, page_next;
    logic                  inmem_reg, inmem_next;
    logic                  below_reg, below_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [PAGE_W-1:0]     kend_reg, kend_next;

    logic                  mv_reg, mv_next;
    logic [STATUS_W-1:0]   mstat_reg, mstat_next;
    logic [PAGE_W-1:0]     mpage_reg, mpage_next;
    logic [REF_OUT_W-1:0]  mref_reg, mref_next;
    logic [FREE_OUT_W-1:0] mfree_reg, mfree_next;

    logic                  accept;
    logic                  exec_fire;
    logic [AW+PAGE_W-1:0]  s_page_ext;
    logic [AW+PAGE_W-1:0]  page_reg_ext;
    logic [AW+PAGE_W-1:0]  got_ext;

    // exec results
    status_t               x_stat;
    logic [PAGE_W-1:0]     x_page;
    logic [REF_WIDTH-1:0]  x_ref;
    logic [REF_WIDTH-1:0]  x_new_ref;
    logic                  x_ref_we;
    logic                  x_alloc_addr;
    logic                  x_push;
    logic                  x_pop;
    logic [REF_WIDTH+REF_OUT_W-1:0] x_ref_ext;
    logic [CW+FREE_OUT_W-1:0]       x_free_ext;

    assign s_page_ext   = {{AW{1'b0}}, s_page};
    assign page_reg_ext = {{AW{1'b0}}, page_reg};
    assign got_ext      = {{AW{1'b0}}, stk_rd_data};

    assign s_ready   = (state_reg == S_IDLE) && !clr_busy;
    assign accept    = s_valid && s_ready;
    assign exec_fire = (state_reg == S_EXEC) && (!mv_reg || m_ready);

    // memory reads are issued on accept; data is ready in S_EXEC
    assign ref_rd_en   = accept;
    assign ref_rd_addr = s_page_ext[AW-1:0];
    assign stk_rd_en   = accept;
    assign stk_rd_addr = AW'(cnt_reg - CW'(1));

    always_comb begin
        x_stat       = STAT_OK;
        x_page       = page_reg;
        x_ref        = ref_rd_data;
        x_new_ref    = ref_rd_data;
        x_ref_we     = 1'b0;
        x_alloc_addr = 1'b0;
        x_push       = 1'b0;
        x_pop        = 1'b0;
        case (act_reg) inside
            ACT_ALLOC: begin
                if (cnt_reg == '0) begin
                    x_stat = STAT_EMPTY;
                    x_page = '0;
                    x_ref  = '0;
                end else begin
                    x_pop        = 1'b1;
                    x_page       = stk_rd_data;
                    x_new_ref    = REF_WIDTH'(1);
                    x_ref        = REF_WIDTH'(1);
                    x_ref_we     = 1'b1;
                    x_alloc_addr = 1'b1;
                end
            end
            ACT_FREE, ACT_SEED: begin
                if (!inmem_reg || below_reg) begin
                    x_stat = STAT_BAD;
                    x_ref  = '0;
                end else begin
                    x_new_ref = (act_reg == ACT_SEED) ? '0 : ref_rd_data;
                    if (x_new_ref != '0) begin
                        x_new_ref = x_new_ref - REF_WIDTH'(1);
                    end
                    x_ref    = x_new_ref;
                    x_ref_we = 1'b1;
                    if (x_new_ref == '0) begin
                        if (cnt_reg == CW'(NUM_PAGES)) begin
                            x_stat = STAT_FULL;
                        end else begin
                            x_push = 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (!inmem_reg) begin
                    x_stat = STAT_BAD;
                    x_ref  = '0;
                end else if (act_reg == ACT_INC) begin
                    if (ref_rd_data != '1) begin
                        x_new_ref = ref_rd_data + REF_WIDTH'(1);
                    end
                    x_ref    = x_new_ref;
                    x_ref_we = 1'b1;
                end else if (act_reg == ACT_DEC) begin
                    if (ref_rd_data != '0) begin
                        x_new_ref = ref_rd_data - REF_WIDTH'(1);
                    end
                    x_ref    = x_new_ref;
                    x_ref_we = 1'b1;
                end
            end
        endcase
    end

    // count memory write port is shared with the clearing sweep
    assign ref_wr_en   = clr_busy || (exec_fire && x_ref_we);
    assign ref_wr_addr = clr_busy     ? clr_addr :
                         x_alloc_addr ? got_ext[AW-1:0] : page_reg_ext[AW-1:0];
    assign ref_wr_data = clr_busy ? '0 : x_new_ref;

    assign stk_wr_en   = exec_fire && x_push;
    assign stk_wr_addr = cnt_reg[AW-1:0];
    assign stk_wr_data = page_reg;

    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        page_next  = page_reg;
        inmem_next = inmem_reg;
        below_next = below_reg;
        cnt_next   = cnt_reg;
        kend_next  = kend_reg;
        mv_next    = mv_reg;
        mstat_next = mstat_reg;
        mpage_next = mpage_reg;
        mref_next  = mref_reg;
        mfree_next = mfree_reg;
        x_ref_ext  = {{REF_OUT_W{1'b0}}, x_ref};
        x_free_ext = '0;

        if (cfg_wr_en) begin
            kend_next = cfg_wr_data;
        end
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    act_next   = s_action;
                    page_next  = s_page;
                    inmem_next = s_page_ext < (AW+PAGE_W)'(NUM_PAGES);
                    below_next = s_page < kend_reg;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_fire) begin
                    if (x_pop) begin
                        cnt_next = cnt_reg - CW'(1);
                    end else if (x_push) begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    x_free_ext = {{FREE_OUT_W{1'b0}}, cnt_next};
                    mv_next    = 1'b1;
                    mstat_next = x_stat;
                    mpage_next = x_page;
                    mref_next  = x_ref_ext[REF_OUT_W-1:0];
                    mfree_next = x_free_ext[FREE_OUT_W-1:0];
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            kend_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            kend_reg  <= kend_next;
            mv_reg    <= mv_next;
        end
        act_reg   <= act_next;
        page_reg  <= page_next;
        inmem_reg <= inmem_next;
        below_reg <= below_next;
        mstat_reg <= mstat_next;
        mpage_reg <= mpage_next;
        mref_reg  <= mref_next;
        mfree_reg <= mfree_next;
    end

    assign m_valid      = mv_reg;
    assign m_status     = mstat_reg;
    assign m_page_out   = mpage_reg;
    assign m_ref_count  = mref_reg;
    assign m_free_pages = mfree_reg;

    // no transaction taken while the count memory is being swept
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready)
        else $error("input accepted during clearing sweep");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(NUM_PAGES))
        else $error("free stack pointer beyond depth");

    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != $past(cnt_reg) |->
            (cnt_reg == $past(cnt_reg) + CW'(1)) || (cnt_reg == $past(cnt_reg) - CW'(1)))
        else $error("free stack pointer moved by more than one");

    a_stack_write_once: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_wr_en |=> !stk_wr_en)
        else $error("two stack pushes in consecutive cycles");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_EMPTY) |-> (m_page_out == '0 && m_free_pages == '0))
        else $error("empty result with nonzero page or free count");

endmodule

`default_nettype wire

/* hw/rtl/refcounted_page_allocator.sv */
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Page frame allocator with per-page reference counts and a LIFO free stack.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+------------------------------
//  s_        | in        | s_valid / s_ready    | s_action, s_page
//  m_        | out       | m_valid / m_ready    | m_status, m_page_out,
//            |           |                      | m_ref_count, m_free_pages
//  cfg_      | in        | cfg_wr_en (no wait)  | cfg_wr_data (kernel end page)
//
//  For each item, accept issues the count and stack memory reads; S_EXEC
//  then modifies and writes back and loads the result register.
//  A new item is taken while the previous result still waits on m_ready;
//  the write-back cycle stalls only while the result register is full.
//  After reset a sweep zeroes all NUM_PAGES entries of the count memory,
//  during which s_ready stays low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_page_allocator
    import rcpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int REF_WIDTH = REF_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [PAGE_W-1:0]     cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ACTION_W-1:0]   s_action,
    input  wire logic [PAGE_W-1:0]     s_page,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic [PAGE_W-1:0]          m_page_out,
    output logic [REF_OUT_W-1:0]       m_ref_count,
    output logic [FREE_OUT_W-1:0]      m_free_pages
);

    localparam int AW = $clog2(NUM_PAGES);

    logic                 clr_busy;
    logic [AW-1:0]        clr_addr;
    logic                 ref_rd_en, ref_wr_en;
    logic [AW-1:0]        ref_rd_addr, ref_wr_addr;
    logic [REF_WIDTH-1:0] ref_rd_data, ref_wr_data;
    logic                 stk_rd_en, stk_wr_en;
    logic [AW-1:0]        stk_rd_addr, stk_wr_addr;
    logic [PAGE_W-1:0]    stk_rd_data, stk_wr_data;

    rcpa_clear #(
        .NUM_PAGES (NUM_PAGES)
    ) u_clear (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clr_busy (clr_busy),
        .clr_addr (clr_addr)
    );

    rcpa_ram #(
        .WIDTH (REF_WIDTH),
        .DEPTH (NUM_PAGES)
    ) u_ref_ram (
        .clk     (aclk),
        .wr_en   (ref_wr_en),
        .wr_addr (ref_wr_addr),
        .wr_data (ref_wr_data),
        .rd_en   (ref_rd_en),
        .rd_addr (ref_rd_addr),
        .rd_data (ref_rd_data)
    );

    rcpa_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .clk     (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    rcpa_core #(
        .NUM_PAGES (NUM_PAGES),
        .REF_WIDTH (REF_WIDTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_page       (s_page),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_page_out   (m_page_out),
        .m_ref_count  (m_ref_count),
        .m_free_pages (m_free_pages),
        .clr_busy     (clr_busy),
        .clr_addr     (clr_addr),
        .ref_rd_en    (ref_rd_en),
        .ref_rd_addr  (ref_rd_addr),
        .ref_rd_data  (ref_rd_data),
        .ref_wr_en    (ref_wr_en),
        .ref_wr_addr  (ref_wr_addr),
        .ref_wr_data  (ref_wr_data),
        .stk_rd_en    (stk_rd_en),
        .stk_rd_addr  (stk_rd_addr),
        .stk_rd_data  (stk_rd_data),
        .stk_wr_en    (stk_wr_en),
        .stk_wr_addr  (stk_wr_addr),
        .stk_wr_data  (stk_wr_data)
    );

endmodule

`default_nettype wire
